FILE: src/pressure_temperature_compensation_macros.svh
// Assertion macros for the pressure and temperature compensation block.
// Every property is sampled on the rising edge of clk and is switched off while in reset.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants of the pressure and temperature compensation.
// ----------------------------------------------------------------------------
package ptc_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TEMP    = 2'd0;
    localparam logic [1:0] CFG_PRESS_A = 2'd1;
    localparam logic [1:0] CFG_PRESS_B = 2'd2;
    localparam logic [1:0] CFG_PRESS_C = 2'd3;

    localparam int DIV_STAGES = 64;

    localparam logic signed [31:0] T_FINE_OFFSET = 32'sd128000;
    localparam logic signed [31:0] TEMP_MIN      = -32'sd4000;
    localparam logic signed [31:0] TEMP_MAX      = 32'sd8500;
    localparam logic [63:0]        B_OFFSET      = 64'h0000_8000_0000_0000;
    localparam logic [63:0]        NUM_SCALE     = 64'd3125;
    localparam logic [20:0]        PRESS_FULL    = 21'h10_0000;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } ptc_coef_t;

    typedef struct packed {
        logic signed [14:0] tc;
        logic               pv;
    } ptc_side_t;

    // Arithmetic right shift of a 64-bit two's complement word.
    function automatic logic [63:0] sar64(input logic [63:0] x, input logic [5:0] n);
        logic signed [63:0] s;
        s = x;
        return s >>> n;
    endfunction

endpackage

FILE: src/pressure_temperature_compensation.sv
// An accepted request passes 4 temperature stages, 7 pressure set-up stages,
// 66 divider stages and 6 finishing stages on its way to the result.
// Throughput: one request per cycle while the output is not stalled; the 64-stage divider sets the depth.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears all valid bits and the four coefficient registers.
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Barometric sensor temperature and pressure compensation, fully pipelined.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation import ptc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic        [19:0] raw_temperature,
    input  logic        [19:0] raw_pressure,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [14:0] temperature_centi,
    output logic        [31:0] pressure_q24_8,
    output logic               pressure_valid,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [1:0]  cfg_index,
    input  logic        [47:0] cfg_data
);

    logic [47:0]        temp_coeffs_reg;
    logic [47:0]        press_a_reg;
    logic [47:0]        press_b_reg;
    logic [47:0]        press_c_reg;
    ptc_coef_t          coef;
    logic               en;
    logic               t_vld;
    logic signed [31:0] t_tf;
    logic        [19:0] t_rp;
    logic               c_vld;
    logic        [63:0] c_num;
    logic signed [31:0] c_den;
    logic signed [14:0] c_tc;
    logic               d_vld;
    logic        [63:0] d_q;
    ptc_side_t          d_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_a_reg     <= '0;
            press_b_reg     <= '0;
            press_c_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TEMP:    temp_coeffs_reg <= cfg_data;
                CFG_PRESS_A: press_a_reg     <= cfg_data;
                CFG_PRESS_B: press_b_reg     <= cfg_data;
                CFG_PRESS_C: press_c_reg     <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        coef.t1 = temp_coeffs_reg[15:0];
        coef.t2 = temp_coeffs_reg[31:16];
        coef.t3 = temp_coeffs_reg[47:32];
        coef.p1 = press_a_reg[15:0];
        coef.p2 = press_a_reg[31:16];
        coef.p3 = press_a_reg[47:32];
        coef.p4 = press_b_reg[15:0];
        coef.p5 = press_b_reg[31:16];
        coef.p6 = press_b_reg[47:32];
        coef.p7 = press_c_reg[15:0];
        coef.p8 = press_c_reg[31:16];
        coef.p9 = press_c_reg[47:32];
    end

    // The pipeline moves whenever the output register is empty or being taken.
    assign en        = !out_valid || !out_stall;
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    ptc_temp u_temp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (in_valid),
        .raw_t     (raw_temperature),
        .raw_p     (raw_pressure),
        .coef      (coef),
        .out_vld   (t_vld),
        .tf        (t_tf),
        .press_raw (t_rp)
    );

    ptc_pcoef u_pcoef
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (t_vld),
        .tf      (t_tf),
        .raw_p   (t_rp),
        .coef    (coef),
        .out_vld (c_vld),
        .num     (c_num),
        .den     (c_den),
        .tc      (c_tc)
    );

    ptc_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (c_vld),
        .num     (c_num),
        .den     (c_den),
        .tc      (c_tc),
        .out_vld (d_vld),
        .q       (d_q),
        .side    (d_side)
    );

    ptc_pout u_pout
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (d_vld),
        .q         (d_q),
        .side_in   (d_side),
        .coef      (coef),
        .out_vld   (out_valid),
        .temp_out  (temperature_centi),
        .press_out (pressure_q24_8),
        .pv_out    (pressure_valid)
    );

endmodule

FILE: src/ptc_mul.sv
// ----------------------------------------------------------------------------
// ptc_mul
// Two-stage 64 x 64 multiplier keeping the low 64 bits of the product.
// ----------------------------------------------------------------------------
module ptc_mul
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0] ll_reg;
    logic [63:0] ll_next;
    logic [31:0] cross_reg;
    logic [31:0] cross_next;
    logic [63:0] p_reg;
    logic [63:0] p_next;

    // Only the low word of the cross terms reaches the low 64 bits.
    always_comb
    begin
        ll_next    = 64'(a[31:0]) * 64'(b[31:0]);
        cross_next = 32'(a[31:0] * b[63:32]) + 32'(a[63:32] * b[31:0]);
        p_next     = ll_reg + {cross_reg, 32'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg    <= ll_next;
            cross_reg <= cross_next;
            p_reg     <= p_next;
        end
    end

    assign p = p_reg;

endmodule

FILE: src/ptc_temp.sv
// ----------------------------------------------------------------------------
// ptc_temp
// Four-stage temperature compensation producing the fine-temperature term.
// ----------------------------------------------------------------------------
module ptc_temp import ptc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic        [19:0] raw_t,
    input  logic        [19:0] raw_p,
    input  ptc_coef_t          coef,
    output logic               out_vld,
    output logic signed [31:0] tf,
    output logic        [19:0] press_raw
);

    logic        [3:0]  vld_reg;
    logic        [19:0] rp_reg [4];
    logic signed [18:0] d1_reg;
    logic signed [18:0] d1_next;
    logic signed [17:0] d2_reg;
    logic signed [17:0] d2_next;
    logic signed [34:0] m1_reg;
    logic signed [34:0] m1_next;
    logic signed [35:0] m2_reg;
    logic signed [35:0] m2_next;
    logic signed [23:0] v1_reg;
    logic signed [23:0] v1_next;
    logic signed [23:0] sq_scaled;
    logic signed [39:0] m3_reg;
    logic signed [39:0] m3_next;
    logic signed [31:0] tf_reg;
    logic signed [31:0] tf_next;

    always_comb
    begin
        d1_next   = {2'b00, raw_t[19:3]} - {1'b0, coef.t1, 1'b0};
        d2_next   = {2'b00, raw_t[19:4]} - {2'b00, coef.t1};
        m1_next   = d1_reg * coef.t2;
        m2_next   = d2_reg * d2_reg;
        v1_next   = 24'(m1_reg >>> 11);
        sq_scaled = 24'(m2_reg >>> 12);
        m3_next   = sq_scaled * coef.t3;
        tf_next   = 32'(v1_reg) + 32'(m3_reg >>> 14);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg    <= d1_next;
            d2_reg    <= d2_next;
            m1_reg    <= m1_next;
            m2_reg    <= m2_next;
            v1_reg    <= v1_next;
            m3_reg    <= m3_next;
            tf_reg    <= tf_next;
            rp_reg[0] <= raw_p;
            rp_reg[1] <= rp_reg[0];
            rp_reg[2] <= rp_reg[1];
            rp_reg[3] <= rp_reg[2];
        end
    end

    assign out_vld   = vld_reg[3];
    assign tf        = tf_reg;
    assign press_raw = rp_reg[3];

endmodule

FILE: src/ptc_pcoef.sv
// ----------------------------------------------------------------------------
// ptc_pcoef
// Seven-stage pressure set-up: forms the division numerator and divisor and
// the saturated temperature output.
// ----------------------------------------------------------------------------
module ptc_pcoef import ptc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic signed [31:0] tf,
    input  logic        [19:0] raw_p,
    input  ptc_coef_t          coef,
    output logic               out_vld,
    output logic        [63:0] num,
    output logic signed [31:0] den,
    output logic signed [14:0] tc
);

    logic        [6:0]  vld_reg;
    logic signed [14:0] tc_reg [7];
    logic signed [14:0] tc_next;
    logic        [19:0] rp_reg [4];
    logic signed [47:0] vp5_reg [3];
    logic signed [47:0] vp5_next;
    logic signed [47:0] vp2_reg [3];
    logic signed [47:0] vp2_next;
    logic signed [31:0] v;
    logic signed [31:0] tcw;
    logic signed [31:0] tc_clamp;
    logic signed [63:0] vv_reg;
    logic signed [63:0] vv_next;
    logic        [63:0] mul6_p;
    logic        [63:0] mul3_p;
    logic        [63:0] mulb_p;
    logic        [63:0] muln_p;
    logic        [63:0] a_reg;
    logic        [63:0] a_next;
    logic        [63:0] b1_reg;
    logic        [63:0] b1_next;
    logic        [20:0] press_diff;
    logic        [63:0] num0_reg;
    logic        [63:0] num0_next;
    logic signed [31:0] den_reg;
    logic signed [31:0] den_next;

    always_comb
    begin
        v        = tf - T_FINE_OFFSET;
        vv_next  = v * v;
        vp5_next = v * coef.p5;
        vp2_next = v * coef.p2;
        tcw      = (tf * 32'sd5 + 32'sd128) >>> 8;
        if (tcw < TEMP_MIN)
        begin
            tc_clamp = TEMP_MIN;
        end
        else if (tcw > TEMP_MAX)
        begin
            tc_clamp = TEMP_MAX;
        end
        else
        begin
            tc_clamp = tcw;
        end
        tc_next    = 15'(tc_clamp);
        a_next     = mul6_p + (64'(vp5_reg[2]) << 17) + (64'(coef.p4) << 35);
        b1_next    = sar64(mul3_p, 6'd8) + (64'(vp2_reg[2]) << 12) + B_OFFSET;
        press_diff = PRESS_FULL - {1'b0, rp_reg[3]};
        num0_next  = (64'(press_diff) << 31) - a_reg;
        den_next   = 32'(sar64(mulb_p, 6'd33));
    end

    ptc_mul u_mul6
    (
        .clk (clk),
        .en  (en),
        .a   (vv_reg),
        .b   (64'(coef.p6)),
        .p   (mul6_p)
    );

    ptc_mul u_mul3
    (
        .clk (clk),
        .en  (en),
        .a   (vv_reg),
        .b   (64'(coef.p3)),
        .p   (mul3_p)
    );

    ptc_mul u_mulb
    (
        .clk (clk),
        .en  (en),
        .a   (b1_reg),
        .b   (64'(coef.p1)),
        .p   (mulb_p)
    );

    ptc_mul u_muln
    (
        .clk (clk),
        .en  (en),
        .a   (num0_reg),
        .b   (NUM_SCALE),
        .p   (muln_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vv_reg     <= vv_next;
            vp5_reg[0] <= vp5_next;
            vp5_reg[1] <= vp5_reg[0];
            vp5_reg[2] <= vp5_reg[1];
            vp2_reg[0] <= vp2_next;
            vp2_reg[1] <= vp2_reg[0];
            vp2_reg[2] <= vp2_reg[1];
            rp_reg[0]  <= raw_p;
            rp_reg[1]  <= rp_reg[0];
            rp_reg[2]  <= rp_reg[1];
            rp_reg[3]  <= rp_reg[2];
            tc_reg[0]  <= tc_next;
            for (int i = 1; i < 7; i++)
            begin
                tc_reg[i] <= tc_reg[i-1];
            end
            a_reg      <= a_next;
            b1_reg     <= b1_next;
            num0_reg   <= num0_next;
            den_reg    <= den_next;
        end
    end

    assign out_vld = vld_reg[6];
    assign num     = muln_p;
    assign den     = den_reg;
    assign tc      = tc_reg[6];

endmodule

FILE: src/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined signed 64 / 32 divider, one quotient bit per stage, truncating
// toward zero.
// ----------------------------------------------------------------------------
module ptc_div import ptc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic        [63:0] num,
    input  logic signed [31:0] den,
    input  logic signed [14:0] tc,
    output logic               out_vld,
    output logic        [63:0] q,
    output ptc_side_t          side
);

    logic [DIV_STAGES:0] vld_reg;
    logic [31:0]         rem_reg  [DIV_STAGES+1];
    logic [63:0]         quo_reg  [DIV_STAGES+1];
    logic [31:0]         dm_reg   [DIV_STAGES+1];
    logic                neg_reg  [DIV_STAGES+1];
    ptc_side_t           side_reg [DIV_STAGES+1];
    logic [63:0]         nmag_next;
    logic [31:0]         dmag_next;
    logic                vld_out_reg;
    logic [63:0]         q_reg;
    logic [63:0]         q_next;
    ptc_side_t           side_out_reg;

    // Work on magnitudes; the sign is restored after the last step.
    always_comb
    begin
        nmag_next = num[63] ? (64'd0 - num) : num;
        dmag_next = den[31] ? (32'd0 - den) : den;
        q_next    = neg_reg[DIV_STAGES] ? (64'd0 - quo_reg[DIV_STAGES])
                                        : quo_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]     <= '0;
            quo_reg[0]     <= nmag_next;
            dm_reg[0]      <= dmag_next;
            neg_reg[0]     <= num[63] ^ den[31];
            side_reg[0].tc <= tc;
            side_reg[0].pv <= (den != 32'sd0);
            q_reg          <= q_next;
            side_out_reg   <= side_reg[DIV_STAGES];
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_step
        logic [32:0] shifted;
        logic        fits;
        logic [31:0] rem_next;

        // The remainder stays below the divisor, so 32 bits hold it.
        always_comb
        begin
            shifted  = {rem_reg[k-1], quo_reg[k-1][63]};
            fits     = (shifted >= {1'b0, dm_reg[k-1]});
            rem_next = fits ? 32'(shifted - {1'b0, dm_reg[k-1]}) : shifted[31:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= {quo_reg[k-1][62:0], fits};
                dm_reg[k]   <= dm_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            vld_out_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[DIV_STAGES-1:0], in_vld};
            vld_out_reg <= vld_reg[DIV_STAGES];
        end
    end

    assign out_vld = vld_out_reg;
    assign q       = q_reg;
    assign side    = side_out_reg;

endmodule

FILE: src/ptc_pout.sv
// ----------------------------------------------------------------------------
// ptc_pout
// Six-stage pressure finish: applies the P7..P9 corrections and holds the
// output register.
// ----------------------------------------------------------------------------
module ptc_pout import ptc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic        [63:0] q,
    input  ptc_side_t          side_in,
    input  ptc_coef_t          coef,
    output logic               out_vld,
    output logic signed [14:0] temp_out,
    output logic        [31:0] press_out,
    output logic               pv_out
);

    logic      [5:0]  vld_reg;
    ptc_side_t        side_reg [6];
    logic      [63:0] q_reg [4];
    logic      [63:0] qs_reg [2];
    logic      [63:0] qs_next;
    logic      [63:0] mulp8_p;
    logic      [63:0] mulp9_p;
    logic      [63:0] mulc_p;
    logic      [63:0] d_reg [2];
    logic      [63:0] d_next;
    logic      [63:0] sum_reg;
    logic      [63:0] sum_next;
    logic      [63:0] r;
    logic      [31:0] press_reg;
    logic      [31:0] press_next;

    always_comb
    begin
        qs_next    = sar64(q, 6'd13);
        d_next     = sar64(mulp8_p, 6'd19);
        sum_next   = q_reg[3] + sar64(mulc_p, 6'd25) + d_reg[1];
        r          = sar64(sum_reg, 6'd8) + (64'(coef.p7) << 4);
        press_next = side_reg[4].pv ? r[31:0] : 32'd0;
    end

    ptc_mul u_mulp8
    (
        .clk (clk),
        .en  (en),
        .a   (q),
        .b   (64'(coef.p8)),
        .p   (mulp8_p)
    );

    ptc_mul u_mulp9
    (
        .clk (clk),
        .en  (en),
        .a   (qs_next),
        .b   (64'(coef.p9)),
        .p   (mulp9_p)
    );

    ptc_mul u_mulc
    (
        .clk (clk),
        .en  (en),
        .a   (mulp9_p),
        .b   (qs_reg[1]),
        .p   (mulc_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0]    <= q;
            q_reg[1]    <= q_reg[0];
            q_reg[2]    <= q_reg[1];
            q_reg[3]    <= q_reg[2];
            qs_reg[0]   <= qs_next;
            qs_reg[1]   <= qs_reg[0];
            d_reg[0]    <= d_next;
            d_reg[1]    <= d_reg[0];
            sum_reg     <= sum_next;
            press_reg   <= press_next;
            side_reg[0] <= side_in;
            for (int i = 1; i < 6; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_vld   = vld_reg[5];
    assign temp_out  = side_reg[5].tc;
    assign press_out = press_reg;
    assign pv_out    = side_reg[5].pv;

endmodule

FILE: src/ptc_checker.sv
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks of the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "pressure_temperature_compensation_macros.svh"

module ptc_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [14:0] temperature_centi,
    input logic        [31:0] pressure_q24_8,
    input logic               pressure_valid
);

    `PTC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

    `PTC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(pressure_q24_8) && $stable(temperature_centi), "stalled result changed")

    // The input side only waits when a finished result is held back.
    `PTC_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output back-pressure")

    `PTC_ASSERT_SAME(a_invalid_zero, out_valid && !pressure_valid, pressure_q24_8 == 32'd0, "invalid pressure not zero")

    `PTC_ASSERT_SAME(a_temp_range, out_valid, temperature_centi >= -15'sd4000 && temperature_centi <= 15'sd8500, "temperature outside saturation range")

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (.*);
